// ----- rtl/dot_star_pattern_matcher_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the dot-star pattern matcher
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef DOT_STAR_PATTERN_MATCHER_ASSERT_SVH
`define DOT_STAR_PATTERN_MATCHER_ASSERT_SVH

// same-cycle implication
`define DSP_ASSERT_NOW(lbl, clk_s, rst_n_s, pre, post) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (pre) |-> (post)) \
		else $error("dsp assertion failed");

// next-cycle implication
`define DSP_ASSERT_NEXT(lbl, clk_s, rst_n_s, pre, post) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (pre) |=> (post)) \
		else $error("dsp assertion failed");

`endif

// ----- rtl/dsp_pkg.sv -----
// ----------------------------------------------------------------------------
// dsp_pkg
// Types and constants shared by the dot-star pattern matcher files.
// ----------------------------------------------------------------------------
package dsp_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int IN_W            = 16;
	localparam int OUT_W           = 8;

	localparam logic [7:0] SYM_ANY  = 8'h2E;
	localparam logic [7:0] SYM_STAR = 8'h2A;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_START  = 2'd2,
		OP_TEXT   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_STAR = 2'd2
	} st_t;

	// wavefront handed from one cell to the next
	typedef struct packed {
		logic       valid;
		logic       adv;   // 1: text byte, 0: build empty-text column
		logic [7:0] sym;
		logic [7:0] pat;   // pattern byte of the sending cell
		logic       c1;    // new column bit of the sending cell
		logic       c2;    // new column bit one cell further back
		logic       old1;  // column bit of the sending cell before update
	} dsp_wave_t;

endpackage

// ----- rtl/dsp_cell.sv -----
// ----------------------------------------------------------------------------
// dsp_cell
// One pattern row: holds its pattern byte, column bit and star-run bit.
// ----------------------------------------------------------------------------
module dsp_cell
	import dsp_pkg::*;
#(
	parameter bit FIRST = 1'b0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      we,
	input  logic [7:0] wdata,
	input  dsp_wave_t wave_in,
	output dsp_wave_t wave_out,
	output logic      col
);

	logic [7:0] pat_q;
	logic       col_q;
	logic       run_q;
	dsp_wave_t  out_q;
	logic       is_star;
	logic       hit;
	logic       prev_hit;
	logic       b;
	logic       e;

	assign is_star  = (pat_q == SYM_STAR);
	assign hit      = (pat_q == SYM_ANY) || (pat_q == wave_in.sym);
	assign prev_hit = (wave_in.pat == SYM_ANY) || (wave_in.pat == wave_in.sym);

	always_comb begin
		b = 1'b0;
		e = 1'b0;
		if (wave_in.adv) begin
			if (!is_star) begin
				b = wave_in.old1 && hit;
			end else if (!FIRST) begin
				e = prev_hit && (wave_in.c1 || run_q);
				b = wave_in.c2 || e;
			end
		end else begin
			b = is_star && wave_in.c2;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			pat_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 1'b0;
			run_q <= 1'b0;
			out_q <= '0;
		end else begin
			out_q.valid <= wave_in.valid;
			if (wave_in.valid) begin
				col_q     <= b;
				run_q     <= e;
				out_q.adv  <= wave_in.adv;
				out_q.sym  <= wave_in.sym;
				out_q.pat  <= pat_q;
				out_q.c1   <= b;
				out_q.c2   <= wave_in.c1;
				out_q.old1 <= col_q;
			end
		end
	end

	assign wave_out = out_q;
	assign col      = col_q;

endmodule

// ----- rtl/dot_star_pattern_matcher.sv -----
// ----------------------------------------------------------------------------
// dot_star_pattern_matcher
// Whole-string matcher for literal, '.' and 'x*' patterns on a cell row.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one item per handshake: an operation and a symbol.
//   Clear and append edit the pattern and restart the text, start restarts
//   the text, a text byte advances the match column by one byte.
//   m_* channel returns one item per input item: matched and a status.
// Timing:
//   Each item sends a wavefront down the row of PATTERN_MAX cells, one
//   cell per cycle, so the column update chain is spread over the row.
//   The result is loaded into the output register when the wavefront leaves
//   the last cell; no new item is taken until then, so the time per item is
//   set by the length of the cell row.
// Reset:
//   Empty pattern, column holds only the empty match, no leading-star
//   flag. Pattern bytes are undefined until appended.
// Stall:
//   A result waiting in the output register does not stop the next item
//   being accepted; if that item's wavefront finishes while the output is
//   still stalled, the block holds the result and takes no further item.
// ----------------------------------------------------------------------------
module dot_star_pattern_matcher
	import dsp_pkg::*;
#(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // [1:0] operation, [9:2] symbol
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // [0] matched, [2:1] status
);

	localparam int LW = $clog2(PATTERN_MAX + 1);

	logic             acc;
	op_t              op;
	logic [7:0]       sym;
	logic             full;
	logic             done;
	logic             out_free;
	logic             load_out;
	logic             res_matched;
	st_t              res_status;

	logic [LW-1:0]    len_q;
	logic             bad_q;
	logic             col0_q;
	logic             drop_q;
	logic             busy_q;
	logic             pend_q;
	logic             ovalid_q;
	logic             omatched_q;
	st_t              ostatus_q;
	dsp_wave_t        tok_q;

	dsp_wave_t        wv [PATTERN_MAX+1];
	logic [PATTERN_MAX:0] cols;
	logic [PATTERN_MAX-1:0] we;

	assign acc  = s_tvalid && s_tready;
	assign op   = op_t'(s_tdata[1:0]);
	assign sym  = s_tdata[9:2];
	assign full = (len_q == LW'(PATTERN_MAX));

	// wavefront source: row zero of the column
	assign wv[0]   = tok_q;
	assign cols[0] = col0_q;

	genvar gi;
	generate
		for (gi = 1; gi <= PATTERN_MAX; gi++) begin : g_cell
			assign we[gi-1] = acc && (op == OP_APPEND) && !full &&
			                  (len_q == LW'(gi - 1));
			dsp_cell #(
				.FIRST (gi == 1)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.we       (we[gi-1]),
				.wdata    (sym),
				.wave_in  (wv[gi-1]),
				.wave_out (wv[gi]),
				.col      (cols[gi])
			);
		end
	endgenerate

	assign done     = wv[PATTERN_MAX].valid;
	assign out_free = !ovalid_q || m_tready;
	assign load_out = (done || pend_q) && out_free;

	// leading star wins unless the byte was dropped
	assign res_matched = bad_q ? 1'b0 : cols[len_q];
	assign res_status  = drop_q ? ST_FULL : (bad_q ? ST_STAR : ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			bad_q    <= 1'b0;
			col0_q   <= 1'b1;
			drop_q   <= 1'b0;
			busy_q   <= 1'b0;
			pend_q   <= 1'b0;
			ovalid_q <= 1'b0;
			tok_q    <= '0;
		end else begin
			tok_q.valid <= acc;
			if (acc) begin
				busy_q     <= 1'b1;
				drop_q     <= (op == OP_APPEND) && full;
				col0_q     <= (op != OP_TEXT);
				tok_q.adv  <= (op == OP_TEXT);
				tok_q.sym  <= sym;
				tok_q.pat  <= '0;
				tok_q.c1   <= (op != OP_TEXT);
				tok_q.c2   <= 1'b0;
				tok_q.old1 <= col0_q;
				case (op)
					OP_CLEAR: begin
						len_q <= '0;
						bad_q <= 1'b0;
					end
					OP_APPEND: begin
						if (!full) begin
							if ((len_q == '0) && (sym == SYM_STAR)) begin
								bad_q <= 1'b1;
							end
							len_q <= len_q + LW'(1);
						end
					end
					default: begin
					end
				endcase
			end
			if (done) begin
				busy_q <= 1'b0;
				if (!out_free) begin
					pend_q <= 1'b1;
				end
			end
			if (load_out) begin
				pend_q   <= 1'b0;
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			omatched_q <= res_matched;
			ostatus_q  <= res_status;
		end
	end

	assign s_tready = !busy_q && !pend_q;
	assign m_tvalid = ovalid_q;
	assign m_tdata  = {{(OUT_W-3){1'b0}}, ostatus_q, omatched_q};

endmodule

// ----- rtl/dsp_checker.sv -----
// ----------------------------------------------------------------------------
// dsp_checker
// Port-level checks on the dot-star pattern matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "dot_star_pattern_matcher_assert.svh"

module dsp_checker
	import dsp_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// a stalled result stays offered
	`DSP_ASSERT_NEXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	// one item at a time: an accepted item closes the input for a while
	`DSP_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// status is never the unused code
	`DSP_ASSERT_NOW(a_status_code, clk, arst_n, m_tvalid, m_tdata[2:1] != 2'd3)
	// a leading-star pattern never matches
	`DSP_ASSERT_NOW(a_star_unmatched, clk, arst_n,
		m_tvalid && (m_tdata[2:1] == ST_STAR), !m_tdata[0])

endmodule

bind dot_star_pattern_matcher dsp_checker u_dsp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
